FILE: rtl/sgen_pkg.sv
// Shared types, constants and tables for the four-channel sound generator.
`default_nettype none
package sgen_pkg;

    localparam int unsigned LEN_TICKS = 4096;
    localparam int unsigned ENV_TICKS = 16384;
    localparam int unsigned LEN_W     = $clog2(LEN_TICKS) + 1;

    localparam logic [14:0] LFSR_SEED = 15'h7FFF;

    localparam logic [15:0] ADDR_SQ1_LO  = 16'hFF11;
    localparam logic [15:0] ADDR_SQ1_HI  = 16'hFF14;
    localparam logic [15:0] ADDR_SQ2_LO  = 16'hFF16;
    localparam logic [15:0] ADDR_SQ2_HI  = 16'hFF19;
    localparam logic [15:0] ADDR_WAV_LO  = 16'hFF1B;
    localparam logic [15:0] ADDR_WAV_HI  = 16'hFF1E;
    localparam logic [15:0] ADDR_NOI_LO  = 16'hFF20;
    localparam logic [15:0] ADDR_NOI_HI  = 16'hFF23;
    localparam logic [15:0] ADDR_PAN     = 16'hFF25;
    localparam logic [15:0] ADDR_MASTER  = 16'hFF26;
    localparam logic [15:0] ADDR_WRAM_LO = 16'hFF30;
    localparam logic [15:0] ADDR_WRAM_HI = 16'hFF3F;

    typedef enum logic [2:0] {
        REG_NONE = 3'd0,
        REG_LEN  = 3'd1,
        REG_ENV  = 3'd2,
        REG_FREQ = 3'd3,
        REG_CTRL = 3'd4
    } chan_reg_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } env_dir_t;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_WRITE = 1'b1
    } action_t;

    typedef struct packed {
        logic [3:0] right_enable;
        logic [3:0] left_enable;
        logic [3:0] level_noise;
        logic [3:0] level_wave;
        logic [3:0] level_square_two;
        logic [3:0] level_square_one;
        logic [3:0] phase_bits;
    } result_t;

    function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] step);
        logic [7:0] pattern;
        begin
            case (duty)
                2'd0:    pattern = 8'b1000_0000;
                2'd1:    pattern = 8'b1000_0001;
                2'd2:    pattern = 8'b1110_0001;
                default: pattern = 8'b0111_1110;
            endcase
            duty_bit = pattern[step];
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/sgen_core.sv
// Channel state and single-pass update for ticks and register writes.
`default_nettype none
module sgen_core
    import sgen_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        action,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  data,
    output result_t          res_next
);

    logic [11:0]      tpos_reg [3];
    logic [11:0]      tpos_next [3];
    logic [10:0]      per_reg [3];
    logic [10:0]      per_next [3];
    logic [31:0]      npos_reg, npos_next;
    logic [17:0]      nper_reg, nper_next;
    logic [5:0]       step_reg [3];
    logic [5:0]       step_next [3];
    logic [3:0]       phase_reg, phase_next;
    logic [1:0]       duty_reg [2];
    logic [1:0]       duty_next [2];
    logic [3:0]       svol_reg [4];
    logic [3:0]       svol_next [4];
    logic [3:0]       vol_reg [4];
    logic [3:0]       vol_next [4];
    logic [LEN_W-1:0] lpos_reg [4];
    logic [LEN_W-1:0] lpos_next [4];
    logic [8:0]       lcnt_reg [4];
    logic [8:0]       lcnt_next [4];
    logic [8:0]       llim_reg [4];
    logic [8:0]       llim_next [4];
    logic [3:0]       len_en_reg, len_en_next;
    logic [31:0]      epos_reg [4];
    logic [31:0]      epos_next [4];
    logic [2:0]       pace_reg [4];
    logic [2:0]       pace_next [4];
    logic [1:0]       edir_reg [4];
    logic [1:0]       edir_next [4];
    logic [14:0]      lfsr_reg, lfsr_next;
    logic             short_reg, short_next;
    logic [7:0]       wram_reg [16];
    logic [7:0]       wram_next [16];
    logic [7:0]       pan_reg, pan_next;
    logic [7:0]       master_reg, master_next;

    logic             wr_hit;
    logic [1:0]       wr_ch;
    chan_reg_t        wr_sel;

    always_comb
    begin
        logic [15:0] off;
        wr_hit = 1'b0;
        wr_ch  = 2'd0;
        off    = 16'd0;
        if (address >= ADDR_SQ1_LO && address <= ADDR_SQ1_HI)
        begin
            wr_hit = 1'b1;
            wr_ch  = 2'd0;
            off    = address - (ADDR_SQ1_LO - 16'd1);
        end
        else if (address >= ADDR_SQ2_LO && address <= ADDR_SQ2_HI)
        begin
            wr_hit = 1'b1;
            wr_ch  = 2'd1;
            off    = address - (ADDR_SQ2_LO - 16'd1);
        end
        else if (address >= ADDR_WAV_LO && address <= ADDR_WAV_HI)
        begin
            wr_hit = 1'b1;
            wr_ch  = 2'd2;
            off    = address - (ADDR_WAV_LO - 16'd1);
        end
        else if (address >= ADDR_NOI_LO && address <= ADDR_NOI_HI)
        begin
            wr_hit = 1'b1;
            wr_ch  = 2'd3;
            off    = address - (ADDR_NOI_LO - 16'd1);
        end
        case (off[2:0])
            3'd1:    wr_sel = REG_LEN;
            3'd2:    wr_sel = REG_ENV;
            3'd3:    wr_sel = REG_FREQ;
            3'd4:    wr_sel = REG_CTRL;
            default: wr_sel = REG_NONE;
        endcase
    end

    always_comb
    begin
        logic [12:0] tp;
        logic [12:0] thr;
        logic [5:0]  st;
        logic [7:0]  wbyte;
        logic [3:0]  nib;
        logic [31:0] np;
        logic        fb;
        logic [14:0] r;
        logic [LEN_W:0] lp;
        logic [31:0] ep;
        logic [31:0] span;
        logic [1:0]  dir;
        logic [4:0]  np5;
        logic        on;

        tpos_next   = tpos_reg;
        per_next    = per_reg;
        npos_next   = npos_reg;
        nper_next   = nper_reg;
        step_next   = step_reg;
        phase_next  = phase_reg;
        duty_next   = duty_reg;
        svol_next   = svol_reg;
        vol_next    = vol_reg;
        lpos_next   = lpos_reg;
        lcnt_next   = lcnt_reg;
        llim_next   = llim_reg;
        len_en_next = len_en_reg;
        epos_next   = epos_reg;
        pace_next   = pace_reg;
        edir_next   = edir_reg;
        lfsr_next   = lfsr_reg;
        short_next  = short_reg;
        wram_next   = wram_reg;
        pan_next    = pan_reg;
        master_next = master_reg;
        tp = '0; thr = '0; st = '0; wbyte = '0; nib = '0; np = '0; fb = 1'b0;
        r = '0; lp = '0; ep = '0; span = '0; dir = '0; np5 = '0; on = 1'b0;

        if (accept && action == ACT_WRITE)
        begin
            if (address == ADDR_PAN)
                pan_next = data;
            else if (address == ADDR_MASTER)
                master_next = data;
            else if (address >= ADDR_WRAM_LO && address <= ADDR_WRAM_HI)
                wram_next[address[3:0]] = data;
            for (int c = 0; c < 4; c++)
            begin
                if (wr_hit && wr_ch == 2'(c))
                begin
                    case (wr_sel)
                        REG_LEN:
                        begin
                            if (c == 2)
                                llim_next[c] = 9'd256 - {1'b0, data};
                            else
                            begin
                                if (c < 2)
                                    duty_next[c[0]] = data[7:6];
                                llim_next[c] = 9'd64 - {3'b0, data[5:0]};
                            end
                        end
                        REG_ENV:
                        begin
                            if (c == 2)
                                svol_next[c] = {2'b0, data[6:5]};
                            else
                            begin
                                dir = data[3] ? DIR_UP : DIR_DOWN;
                                svol_next[c] = data[7:4];
                                edir_next[c] = dir;
                                if (pace_reg[c] == 3'd0)
                                    vol_next[c] = vol_reg[c] + ((dir == DIR_UP) ? 4'd1 : 4'd2);
                                else if (dir != edir_reg[c])
                                    vol_next[c] = 4'd0 - vol_reg[c];
                                pace_next[c] = data[2:0];
                            end
                        end
                        REG_FREQ:
                        begin
                            if (c == 3)
                            begin
                                np5 = {data[2:0], 2'b00};
                                if (np5 == 5'd0)
                                    np5 = 5'd2;
                                nper_next  = (data[7:4] < 4'd14) ?
                                             ({13'd0, np5} << data[7:4]) : 18'd0;
                                short_next = data[3];
                            end
                            else
                                per_next[c[1:0]] = {per_reg[c[1:0]][10:8], data};
                        end
                        REG_CTRL:
                        begin
                            if (c != 3)
                                per_next[c[1:0]] = {data[2:0], per_reg[c[1:0]][7:0]};
                            len_en_next[c] = data[6];
                            if (data[7])
                            begin
                                if (c == 3)
                                begin
                                    npos_next = '0;
                                    lfsr_next = LFSR_SEED;
                                end
                                else
                                    tpos_next[c[1:0]] = '0;
                                vol_next[c]  = svol_reg[c];
                                lpos_next[c] = '0;
                                lcnt_next[c] = '0;
                                epos_next[c] = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
        else if (accept)
        begin
            for (int c = 0; c < 4; c++)
            begin
                lp = {1'b0, lpos_reg[c]} + (LEN_W+1)'(1);
                if (lp >= (LEN_W+1)'(LEN_TICKS))
                begin
                    lp = lp - (LEN_W+1)'(LEN_TICKS);
                    if (lcnt_reg[c] < llim_reg[c])
                        lcnt_next[c] = lcnt_reg[c] + 9'd1;
                end
                lpos_next[c] = lp[LEN_W-1:0];
                if (c != 2)
                begin
                    span = 32'(ENV_TICKS) * {29'd0, pace_reg[c]};
                    ep   = epos_reg[c] + 32'd1;
                    if (pace_reg[c] != 3'd0 && ep >= span)
                    begin
                        ep = ep - span;
                        if (edir_reg[c] == DIR_DOWN && vol_reg[c] > 4'd0)
                            vol_next[c] = vol_reg[c] - 4'd1;
                        else if (edir_reg[c] == DIR_UP && vol_reg[c] < 4'd15)
                            vol_next[c] = vol_reg[c] + 4'd1;
                    end
                    epos_next[c] = ep;
                end
            end
            for (int c = 0; c < 3; c++)
            begin
                tp  = {1'b0, tpos_reg[c]} + ((c == 2) ? 13'd2 : 13'd1);
                thr = 13'd2048 - {2'b0, per_reg[c]};
                if (tp >= thr)
                begin
                    tp = '0;
                    st = step_reg[c];
                    if (c == 2)
                    begin
                        if (st >= 6'd32)
                            st = '0;
                        wbyte = wram_reg[st[4:1]];
                        nib   = st[0] ? wbyte[3:0] : wbyte[7:4];
                        phase_next[c] = 1'b1;
                        case (svol_reg[2][1:0])
                            2'd0:    nib = 4'd0;
                            2'd2:    nib = nib >> 1;
                            2'd3:    nib = nib >> 2;
                            default: nib = nib;
                        endcase
                        vol_next[2] = nib;
                    end
                    else
                    begin
                        if (st >= 6'd8)
                            st = '0;
                        phase_next[c] = duty_bit(duty_reg[c[0]], st[2:0]);
                    end
                    step_next[c] = st + 6'd1;
                end
                tpos_next[c] = tp[11:0];
            end
            np = npos_reg + 32'd1;
            if (nper_reg != '0 && np >= {14'd0, nper_reg})
            begin
                np = '0;
                r  = lfsr_reg;
                fb = r[0] ^ r[1];
                phase_next[3] = ~r[0];
                r = {fb, r[14:1]};
                if (short_reg)
                    r[6] = r[14];
                lfsr_next = r;
            end
            npos_next = np;
        end

        res_next.phase_bits       = phase_next;
        res_next.level_square_one = vol_next[0];
        res_next.level_square_two = vol_next[1];
        res_next.level_wave       = vol_next[2];
        res_next.level_noise      = vol_next[3];
        for (int c = 0; c < 4; c++)
        begin
            on = !(len_en_next[c] && lcnt_next[c] == llim_next[c]) && master_next[7];
            res_next.left_enable[c]  = on && pan_next[c+4];
            res_next.right_enable[c] = on && pan_next[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                tpos_reg[c] <= '0;
                per_reg[c]  <= '0;
                step_reg[c] <= '0;
            end
            for (int c = 0; c < 2; c++)
                duty_reg[c] <= '0;
            for (int c = 0; c < 4; c++)
            begin
                svol_reg[c] <= '0;
                vol_reg[c]  <= '0;
                lpos_reg[c] <= '0;
                lcnt_reg[c] <= '0;
                llim_reg[c] <= '0;
                epos_reg[c] <= '0;
                pace_reg[c] <= '0;
                edir_reg[c] <= DIR_NONE;
            end
            for (int i = 0; i < 16; i++)
                wram_reg[i] <= '0;
            npos_reg   <= '0;
            nper_reg   <= '0;
            phase_reg  <= '0;
            len_en_reg <= '0;
            lfsr_reg   <= LFSR_SEED;
            short_reg  <= 1'b0;
            pan_reg    <= '0;
            master_reg <= '0;
        end
        else
        begin
            tpos_reg   <= tpos_next;
            per_reg    <= per_next;
            step_reg   <= step_next;
            duty_reg   <= duty_next;
            svol_reg   <= svol_next;
            vol_reg    <= vol_next;
            lpos_reg   <= lpos_next;
            lcnt_reg   <= lcnt_next;
            llim_reg   <= llim_next;
            epos_reg   <= epos_next;
            pace_reg   <= pace_next;
            edir_reg   <= edir_next;
            wram_reg   <= wram_next;
            npos_reg   <= npos_next;
            nper_reg   <= nper_next;
            phase_reg  <= phase_next;
            len_en_reg <= len_en_next;
            lfsr_reg   <= lfsr_next;
            short_reg  <= short_next;
            pan_reg    <= pan_next;
            master_reg <= master_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/four_channel_sound_generator.sv
// The result of an accepted request appears on the master side in the cycle after it is accepted.
// Throughput: one request per cycle while m_tready is high; the result register frees as it is taken.
// The channel update is a single combinational pass into the state and result registers.
// Reset: asynchronous, active low; channel state clears, noise LFSR loads 0x7FFF,
// wave RAM clears, and no result is pending.
`default_nettype none
module four_channel_sound_generator
    import sgen_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // address[15:0], data[23:16]
    input  wire logic        s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // phase_bits, level_square_one, level_square_two,
                                        // level_wave, level_noise, left_enable,
                                        // right_enable, 4 bits each; zero pad
);

    logic    valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    accept;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    sgen_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .action   (s_tuser),
        .address  (s_tdata[15:0]),
        .data     (s_tdata[23:16]),
        .res_next (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, res_reg};

endmodule
`default_nettype wire

FILE: rtl/sgen_checker.sv
// Port-level checks for the sound generator and their binding to the top level.
`default_nettype none
module sgen_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request produced no result");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow result register");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:28] == 4'd0)
        else $error("result padding not zero");

endmodule

bind four_channel_sound_generator sgen_checker u_sgen_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
